// ===== hdl/gcp_pkg.sv =====
// Shared types, codes and constants for the grid cell placer.
`default_nettype none

package gcp_pkg;

    // Default grid limits
    localparam int DEF_MAX_COLS = 16;
    localparam int DEF_MAX_ROWS = 16;

    // Stream widths
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 6;
    localparam int M_TDATA_W  = 24;
    localparam int OUT_USED_W = 18;
    localparam int OUT_PAD_W  = M_TDATA_W - OUT_USED_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0]  REG_NUM_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_NUM_ROWS = 1'd1;
    localparam logic [CFG_DATA_W-1:0] CNT_RESET    = 5'd16;

    // Request codes
    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_RESERVE = 2'd1;
    localparam logic [1:0] REQ_PLACE   = 2'd2;

    // Placement modes; auto and area both fall to the default
    localparam logic [1:0] MODE_LINE = 2'd1;
    localparam logic [1:0] MODE_SPAN = 2'd2;

    // Signed grid coordinate: holds line values, spans and their sums
    localparam int POS_W = 9;
    typedef logic signed [POS_W-1:0] pos_t;
    localparam pos_t POS_ZERO = '0;
    localparam pos_t POS_ONE  = 9'sd1;

    // Controller to datapath
    typedef struct packed {
        logic load_place;
        logic load_reserve;
        logic clear_map;
        logic skip_row;
        logic next_col;
        logic ri_start;
        logic ri_step;
        logic mark_wr;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       both_line;
        logic       row_done;
        logic       overrun;
        logic       empty_window;
        logic       rspan_empty;
        logic       row_taken;
        logic       last_row;
    } sts_t;

    // Zero counts as one, anything above the maximum saturates
    function automatic pos_t limit_count(logic [CFG_DATA_W-1:0] v, pos_t maxv);
        pos_t x;
        x = pos_t'({{(POS_W-CFG_DATA_W){1'b0}}, v});
        if (x == POS_ZERO) begin
            return POS_ONE;
        end
        if (x > maxv) begin
            return maxv;
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/grid_cell_placer.sv =====
// Top level of the grid cell placer: controller plus datapath.
//
//  Channel   Direction  Handshake          Contents
//  s_        in         s_tvalid/s_tready  request word (tuser: kind and modes, tdata: values)
//  m_        out        m_tvalid/m_tready  placed item start/end indices
//  cfg_      in         cfg_wr_en          column and row counts
//
// Clear words are taken in idle; reserve words go through the marking states. A place word
// runs a first-fit search: each candidate position is tested row by row over its window, each
// row read, then checked (one memory read port); then each spanned row is read and marked.
// Reset clears control and the per-row valid bits at once; no clearing pass.
// A finished result sits in the output register while the next word is taken;
// a later result waits until that register is free.
`default_nettype none

module grid_cell_placer #(
    parameter int MAX_COLS = gcp_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gcp_pkg::DEF_MAX_ROWS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [6:0] col_value, [13:7] row_value, [15:14] zero
    input  wire logic [gcp_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] req_type, [3:2] col_mode, [5:4] row_mode
    input  wire logic [gcp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [3:0] col_first, [8:4] col_end, [12:9] row_first, [17:13] row_end, [23:18] zero
    output logic      [gcp_pkg::M_TDATA_W-1:0]  m_tdata
);
    import gcp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gcp_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== hdl/gcp_datapath.sv =====
// Datapath: config registers, occupancy memory, search cursor and result register.
`default_nettype none

module gcp_datapath #(
    parameter int MAX_COLS = gcp_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = gcp_pkg::DEF_MAX_ROWS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [gcp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gcp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [gcp_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic [gcp_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic      [gcp_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire gcp_pkg::cmd_t                  cmd,
    output gcp_pkg::sts_t                       sts
);
    import gcp_pkg::*;

    localparam int   ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam pos_t MAX_C  = pos_t'(MAX_COLS);
    localparam pos_t MAX_R  = pos_t'(MAX_ROWS);

    logic [CFG_DATA_W-1:0] num_cols_reg, num_rows_reg;
    pos_t cs_reg, cs_next, rs_reg, rs_next;
    pos_t cspan_reg, cspan_next, rspan_reg, rspan_next;
    pos_t ri_reg, ri_next;
    pos_t nc, nr, ce, re, cs_inc;
    pos_t first_c, end_c, first_r, end_r;

    logic [1:0]          req_type, col_mode, row_mode;
    logic signed [6:0]   col_value, row_value;
    pos_t                col_val_ext, row_val_ext;

    logic [MAX_COLS-1:0] occ_mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_word_reg, row_word, col_mask;
    logic                rd_valid_reg;
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [ROW_AW-1:0]   addr;
    logic                row_in;

    logic [3:0] col_first_reg, row_first_reg;
    logic [4:0] col_end_reg, row_end_reg;

    // Word fields
    assign req_type    = s_tuser[1:0];
    assign col_mode    = s_tuser[3:2];
    assign row_mode    = s_tuser[5:4];
    assign col_value   = s_tdata[6:0];
    assign row_value   = s_tdata[13:7];
    assign col_val_ext = pos_t'(col_value);
    assign row_val_ext = pos_t'(row_value);

    assign nc     = limit_count(num_cols_reg, MAX_C);
    assign nr     = limit_count(num_rows_reg, MAX_R);
    assign ce     = cs_reg + cspan_reg;
    assign re     = rs_reg + rspan_reg;
    assign cs_inc = cs_reg + POS_ONE;
    assign addr   = ri_reg[ROW_AW-1:0];
    assign row_in = !ri_reg[POS_W-1] && (ri_reg < nr);

    // In-grid columns covered by the current window
    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            col_mask[c] = (pos_t'(c) >= cs_reg) && (pos_t'(c) < ce) && (pos_t'(c) < nc);
        end
    end

    assign row_word = rd_valid_reg ? rd_word_reg : '0;

    // Status
    always_comb begin
        sts.req_type     = req_type;
        sts.both_line    = (col_mode == MODE_LINE) && (row_mode == MODE_LINE);
        sts.row_done     = (rs_reg >= nr);
        sts.overrun      = (ce > nc);
        sts.empty_window = (cspan_reg < POS_ONE) || (rspan_reg < POS_ONE);
        sts.rspan_empty  = (rspan_reg < POS_ONE);
        // off-grid cells count as taken
        sts.row_taken    = !row_in || cs_reg[POS_W-1] || (|(row_word & col_mask));
        sts.last_row     = ((ri_reg + POS_ONE) >= re);
    end

    // Cursor and span updates
    always_comb begin
        cs_next    = cs_reg;
        rs_next    = rs_reg;
        cspan_next = cspan_reg;
        rspan_next = rspan_reg;
        priority if (cmd.load_place) begin
            cs_next    = (col_mode == MODE_LINE) ? col_val_ext : POS_ZERO;
            rs_next    = (row_mode == MODE_LINE) ? row_val_ext : POS_ZERO;
            cspan_next = (col_mode == MODE_SPAN) ? col_val_ext : POS_ONE;
            rspan_next = (row_mode == MODE_SPAN) ? row_val_ext : POS_ONE;
        end else if (cmd.load_reserve) begin
            cs_next    = col_val_ext;
            rs_next    = row_val_ext;
            cspan_next = POS_ONE;
            rspan_next = POS_ONE;
        end else if (cmd.skip_row) begin
            cs_next = POS_ZERO;
            rs_next = rs_reg + POS_ONE;
        end else if (cmd.next_col) begin
            if (cs_inc >= nc) begin
                cs_next = POS_ZERO;
                rs_next = rs_reg + POS_ONE;
            end else begin
                cs_next = cs_inc;
            end
        end else begin
            cs_next = cs_reg;
        end

        priority if (cmd.ri_start) begin
            ri_next = rs_reg;
        end else if (cmd.ri_step) begin
            ri_next = ri_reg + POS_ONE;
        end else begin
            ri_next = ri_reg;
        end
    end

    always_ff @(posedge aclk) begin
        cs_reg    <= cs_next;
        rs_reg    <= rs_next;
        cspan_reg <= cspan_next;
        rspan_reg <= rspan_next;
        ri_reg    <= ri_next;
    end

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= CNT_RESET;
            num_rows_reg <= CNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUM_COLS: num_cols_reg <= cfg_data;
                REG_NUM_ROWS: num_rows_reg <= cfg_data;
            endcase
        end
    end

    // Occupancy memory, one row word per entry; registered read at the row cursor
    always_ff @(posedge aclk) begin
        if (cmd.mark_wr && row_in) begin
            occ_mem[addr] <= row_word | col_mask;
        end
        rd_word_reg  <= occ_mem[addr];
        rd_valid_reg <= row_valid_reg[addr];
    end

    // A row never written since reset or clear reads as free
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_map) begin
            row_valid_reg <= '0;
        end else if (cmd.mark_wr && row_in) begin
            row_valid_reg[addr] <= 1'b1;
        end
    end

    // Clamp to the grid
    always_comb begin
        first_c = cs_reg[POS_W-1] ? POS_ZERO : ((cs_reg > nc - POS_ONE) ? nc - POS_ONE : cs_reg);
        end_c   = (ce < POS_ONE) ? POS_ONE : ((ce > nc) ? nc : ce);
        first_r = rs_reg[POS_W-1] ? POS_ZERO : ((rs_reg > nr - POS_ONE) ? nr - POS_ONE : rs_reg);
        end_r   = (re < POS_ONE) ? POS_ONE : ((re > nr) ? nr : re);
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            col_first_reg <= first_c[3:0];
            col_end_reg   <= end_c[4:0];
            row_first_reg <= first_r[3:0];
            row_end_reg   <= end_r[4:0];
        end
    end

    assign m_tdata = {{OUT_PAD_W{1'b0}}, row_end_reg, row_first_reg, col_end_reg, col_first_reg};

endmodule

`default_nettype wire

// ===== hdl/gcp_ctrl.sv =====
// Controller: sequences clear, reserve, first-fit search, marking and result hand-off.
`default_nettype none

module gcp_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    input  wire gcp_pkg::sts_t sts,
    output gcp_pkg::cmd_t      cmd
);
    import gcp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TEST_RD,
        ST_TEST_CHK,
        ST_MARK_INIT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   place_reg, place_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        place_next = place_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (sts.req_type)
                        REQ_CLEAR: begin
                            cmd.clear_map = 1'b1;
                        end
                        REQ_RESERVE: begin
                            if (sts.both_line) begin
                                cmd.load_reserve = 1'b1;
                                place_next       = 1'b0;
                                state_next       = ST_MARK_INIT;
                            end
                        end
                        REQ_PLACE: begin
                            cmd.load_place = 1'b1;
                            place_next     = 1'b1;
                            state_next     = sts.both_line ? ST_MARK_INIT : ST_SEARCH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                priority if (sts.row_done) begin
                    // no fit: keep the position reached
                    state_next = ST_MARK_INIT;
                end else if (sts.overrun) begin
                    cmd.skip_row = 1'b1;
                end else if (sts.empty_window) begin
                    state_next = ST_MARK_INIT;
                end else begin
                    cmd.ri_start = 1'b1;
                    state_next   = ST_TEST_RD;
                end
            end
            ST_TEST_RD: begin
                state_next = ST_TEST_CHK;
            end
            ST_TEST_CHK: begin
                priority if (sts.row_taken) begin
                    cmd.next_col = 1'b1;
                    state_next   = ST_SEARCH;
                end else if (sts.last_row) begin
                    state_next = ST_MARK_INIT;
                end else begin
                    cmd.ri_step = 1'b1;
                    state_next  = ST_TEST_RD;
                end
            end
            ST_MARK_INIT: begin
                cmd.ri_start = 1'b1;
                state_next   = sts.rspan_empty ? ST_FINISH : ST_MARK_RD;
            end
            ST_MARK_RD: begin
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                cmd.mark_wr = 1'b1;
                if (sts.last_row) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.ri_step = 1'b1;
                    state_next  = ST_MARK_RD;
                end
            end
            ST_FINISH: begin
                if (!place_reg) begin
                    state_next = ST_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            place_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            place_reg     <= place_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
